// ----- src/tec_pkg.sv -----
// ----------------------------------------------------------------------------
// tec_pkg
// Shared types and constants of the touch event calibrator: event kinds,
// register indexes, register reset values and calibration constants.
// ----------------------------------------------------------------------------
package tec_pkg;

    // Default widths of the raw readings and of the screen resolution.
    localparam int RAW_BITS_DEF    = 16;
    localparam int SCREEN_BITS_DEF = 12;

    // Byte address width of the configuration port (six 32-bit registers).
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Calibration constants: the span is shrunk by 30 pixels and offset by 15.
    localparam int CAL_SHRINK = 30;
    localparam int CAL_MARGIN = 15;

    // Pressure reported while touched and after release.
    localparam logic [7:0] PRESS_DOWN = 8'hFF;
    localparam logic [7:0] PRESS_UP   = 8'h00;

    // Register reset values.
    localparam int RST_MIN    = 0;
    localparam int RST_MAX    = 4095;
    localparam int RST_WIDTH  = 320;
    localparam int RST_HEIGHT = 240;

    typedef enum logic [1:0] {
        KIND_ABS_X = 2'd0,
        KIND_ABS_Y = 2'd1,
        KIND_KEY   = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_X_MIN  = 3'd0,
        REG_X_MAX  = 3'd1,
        REG_Y_MIN  = 3'd2,
        REG_Y_MAX  = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } t_reg_idx;

endpackage

// ----- src/touch_event_calibrator.sv -----
// ----------------------------------------------------------------------------
// touch_event_calibrator
// Linear touchscreen calibration of raw input events with position reports.
// ----------------------------------------------------------------------------
// The block takes one raw touch event per input word: tuser carries the event
// kind (absolute X, absolute Y, touch key, other) and tdata the raw value. An
// absolute coordinate is scaled as ((v - min) * (res - 30)) / (max - min) + 15
// with signed arithmetic and a quotient truncated toward zero; a zero span
// gives a scaled term of zero. The value is clamped to 0..res, mirrored as
// res - v and held. A report word (pos_x, pos_y, pressure) follows when the
// other coordinate is valid. A touch-down sets pressure to 255 and marks both
// coordinates invalid (-1) without a report; a touch-up sets pressure to 0
// and always reports. Other events are dropped. A coordinate event occupies
// the block from acceptance through subtract, multiply, divider load, divide,
// finish and commit; the serial divider retires one quotient bit per cycle.
// Key and other events go straight to commit. The report sits in an output
// register, so the block only stalls at the commit step when a previous
// report has not been taken. Configuration registers are to be written
// through the APB port while idle by the user; the block does not enforce it.
// ----------------------------------------------------------------------------
module touch_event_calibrator
    import tec_pkg::*;
#(
    parameter int RAW_BITS    = RAW_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF,
    parameter int IN_BITS     = ((RAW_BITS + 7) / 8) * 8,
    parameter int OUT_BITS    = ((2 * (SCREEN_BITS + 1) + 8 + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input events.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_BITS-1:0]   i_s_tdata,   // raw_value
    input  logic [1:0]           i_s_tuser,   // req_type
    // Position reports.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_BITS-1:0]  o_m_tdata,   // pos_x, pos_y, pressure
    // Configuration.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    localparam int POS_BITS  = SCREEN_BITS + 1;
    localparam int PROD_BITS = RAW_BITS + SCREEN_BITS + 2;

    localparam logic signed [PROD_BITS:0]   MARGIN_W = (PROD_BITS + 1)'(CAL_MARGIN);
    localparam logic signed [SCREEN_BITS:0] SHRINK_W = (SCREEN_BITS + 1)'(CAL_SHRINK);
    localparam logic [POS_BITS-1:0]         POS_NONE = {POS_BITS{1'b1}};

    // The sequencer walks one coordinate through subtract, multiply, divider load,
    // divide, finish and commit. Key and other events go straight to commit.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SUB    = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_COMMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration values.
    logic [RAW_BITS-1:0]    w_x_min, w_x_max, w_y_min, w_y_max;
    logic [SCREEN_BITS-1:0] w_width, w_height;

    // Accepted event.
    t_kind               r_kind;
    logic [RAW_BITS-1:0] r_raw;

    // Datapath registers.
    logic signed [RAW_BITS:0]    r_diff;
    logic signed [RAW_BITS:0]    r_span;
    logic signed [SCREEN_BITS:0] r_factor;
    logic [SCREEN_BITS-1:0]      r_res;
    logic signed [PROD_BITS-1:0] r_prod;
    logic [POS_BITS-1:0]         r_calc;

    // Held state.
    logic [POS_BITS-1:0] r_held_x;
    logic [POS_BITS-1:0] r_held_y;
    logic [7:0]          r_held_p;

    // Output register.
    logic                r_ovalid;
    logic [POS_BITS-1:0] r_out_x;
    logic [POS_BITS-1:0] r_out_y;
    logic [7:0]          r_out_p;

    logic                        w_accept;
    logic                        w_commit;
    logic                        w_is_x;
    logic                        w_div_done;
    logic signed [PROD_BITS-1:0] w_quot;
    logic signed [PROD_BITS:0]   w_sum;
    logic signed [PROD_BITS:0]   w_res;
    logic signed [PROD_BITS:0]   w_clamp;
    logic signed [PROD_BITS:0]   w_mirror;
    logic                        w_report;
    logic [POS_BITS-1:0]         n_held_x;
    logic [POS_BITS-1:0]         n_held_y;
    logic [7:0]                  n_held_p;

    tec_cfg_regs #(
        .RAW_BITS    (RAW_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_x_min  (w_x_min),
        .o_x_max  (w_x_max),
        .o_y_min  (w_y_min),
        .o_y_max  (w_y_max),
        .o_width  (w_width),
        .o_height (w_height)
    );

    tec_divider #(
        .NUM_BITS (PROD_BITS),
        .DEN_BITS (RAW_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid & o_s_tready;
    // A commit waits until the output register is free or being emptied.
    assign w_commit   = (r_state == S_COMMIT) & (~r_ovalid | i_m_tready);
    assign w_is_x     = (r_kind == KIND_ABS_X);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser[1]) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_SUB;
                    end
                end
            end
            S_SUB:  n_state = S_MUL;
            S_MUL:  n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_COMMIT;
            S_COMMIT: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_kind'(i_s_tuser);
            r_raw  <= i_s_tdata[RAW_BITS-1:0];
        end
    end

    // Subtract stage: offset, span and resolution factor of the chosen axis.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUB) begin
            if (w_is_x) begin
                r_diff <= $signed({1'b0, r_raw}) - $signed({1'b0, w_x_min});
                r_span <= $signed({1'b0, w_x_max}) - $signed({1'b0, w_x_min});
                r_res  <= w_width;
                r_factor <= $signed({1'b0, w_width}) - SHRINK_W;
            end else begin
                r_diff <= $signed({1'b0, r_raw}) - $signed({1'b0, w_y_min});
                r_span <= $signed({1'b0, w_y_max}) - $signed({1'b0, w_y_min});
                r_res  <= w_height;
                r_factor <= $signed({1'b0, w_height}) - SHRINK_W;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= r_diff * r_factor;
        end
    end

    // Finish: add the margin, clamp to 0..res and mirror.
    always_comb begin
        w_res = $signed({{(PROD_BITS + 1 - SCREEN_BITS){1'b0}}, r_res});
        if (r_span == '0) begin
            w_sum = MARGIN_W;
        end else begin
            w_sum = $signed({w_quot[PROD_BITS-1], w_quot}) + MARGIN_W;
        end
        if (w_sum < 0) begin
            w_clamp = '0;
        end else if (w_sum > w_res) begin
            w_clamp = w_res;
        end else begin
            w_clamp = w_sum;
        end
        w_mirror = w_res - w_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_calc <= {1'b0, w_mirror[SCREEN_BITS-1:0]};
        end
    end

    // Commit: update the held state and decide whether a report goes out.
    always_comb begin
        n_held_x = r_held_x;
        n_held_y = r_held_y;
        n_held_p = r_held_p;
        w_report = 1'b0;
        case (r_kind)
            KIND_ABS_X: begin
                n_held_x = r_calc;
                w_report = (r_held_y != POS_NONE);
            end
            KIND_ABS_Y: begin
                n_held_y = r_calc;
                w_report = (r_held_x != POS_NONE);
            end
            KIND_KEY: begin
                if (r_raw != '0) begin
                    n_held_p = PRESS_DOWN;
                    n_held_x = POS_NONE;
                    n_held_y = POS_NONE;
                end else begin
                    n_held_p = PRESS_UP;
                    w_report = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
            r_held_p <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // A new report refills the register even as the old one leaves.
            if (w_commit && w_report) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_commit) begin
                r_held_x <= n_held_x;
                r_held_y <= n_held_y;
                r_held_p <= n_held_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && w_report) begin
            r_out_x <= n_held_x;
            r_out_y <= n_held_y;
            r_out_p <= n_held_p;
        end
    end

    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[POS_BITS-1:0]              = r_out_x;
        o_m_tdata[2*POS_BITS-1:POS_BITS]     = r_out_y;
        o_m_tdata[2*POS_BITS+7:2*POS_BITS]   = r_out_p;
    end

    assign o_m_tvalid = r_ovalid;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    // A coordinate event starts the arithmetic, a key or other event goes to commit.
    a_accept_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_s_tuser[1]) |=> (r_state == S_SUB))
        else $error("coordinate event did not enter the subtract step");

    a_key_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tuser[1]) |=> (r_state == S_COMMIT))
        else $error("key event did not go to commit");

    // A held coordinate is either a pixel position or the invalid mark.
    a_held_x_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_x[POS_BITS-1] |-> (r_held_x == POS_NONE))
        else $error("held X is negative but not the invalid mark");

    // Reported pressure is only ever touched or released.
    a_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out_p == PRESS_DOWN || r_out_p == PRESS_UP))
        else $error("reported pressure is neither touched nor released");

endmodule

// ----- src/tec_divider.sv -----
// ----------------------------------------------------------------------------
// tec_divider
// Serial signed divider: one restoring step per cycle on the magnitudes,
// then a sign fix. The quotient truncates toward zero.
// ----------------------------------------------------------------------------
module tec_divider #(
    parameter int NUM_BITS = 30,
    parameter int DEN_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [NUM_BITS-1:0] i_dividend,
    input  logic signed [DEN_BITS:0]   i_divisor,
    output logic                       o_done,
    output logic signed [NUM_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_neg;
    logic [CNT_BITS-1:0]        r_cnt;
    logic [NUM_BITS-1:0]        r_num;
    logic [DEN_BITS-1:0]        r_den;
    logic [DEN_BITS-1:0]        r_rem;
    logic signed [NUM_BITS-1:0] r_quot;

    logic [DEN_BITS:0]   w_shift;
    logic [DEN_BITS+1:0] w_sub;
    logic                w_ge;
    logic [DEN_BITS:0]   w_den_neg;

    assign w_shift   = {r_rem, r_num[NUM_BITS-1]};
    assign w_sub     = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge      = ~w_sub[DEN_BITS+1];
    assign w_den_neg = -i_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Done pulses for one cycle once the last step has been taken.
            r_done <= ~i_start & r_busy & (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The dividend register shifts left and collects quotient bits at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend[NUM_BITS-1] ? NUM_BITS'(-i_dividend)
                                            : NUM_BITS'(i_dividend);
            r_den <= i_divisor[DEN_BITS] ? w_den_neg[DEN_BITS-1:0]
                                         : i_divisor[DEN_BITS-1:0];
            r_rem <= '0;
            r_neg <= i_dividend[NUM_BITS-1] ^ i_divisor[DEN_BITS];
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_num <= {r_num[NUM_BITS-2:0], w_ge};
                r_rem <= w_ge ? w_sub[DEN_BITS-1:0] : w_shift[DEN_BITS-1:0];
            end else begin
                r_quot <= r_neg ? -$signed(r_num) : $signed(r_num);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- src/tec_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tec_cfg_regs
// Calibration and resolution registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module tec_cfg_regs
    import tec_pkg::*;
#(
    parameter int RAW_BITS    = RAW_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready,
    output logic [RAW_BITS-1:0]    o_x_min,
    output logic [RAW_BITS-1:0]    o_x_max,
    output logic [RAW_BITS-1:0]    o_y_min,
    output logic [RAW_BITS-1:0]    o_y_max,
    output logic [SCREEN_BITS-1:0] o_width,
    output logic [SCREEN_BITS-1:0] o_height
);

    logic [RAW_BITS-1:0]    r_x_min;
    logic [RAW_BITS-1:0]    r_x_max;
    logic [RAW_BITS-1:0]    r_y_min;
    logic [RAW_BITS-1:0]    r_y_max;
    logic [SCREEN_BITS-1:0] r_width;
    logic [SCREEN_BITS-1:0] r_height;

    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min  <= RAW_BITS'(RST_MIN);
            r_x_max  <= RAW_BITS'(RST_MAX);
            r_y_min  <= RAW_BITS'(RST_MIN);
            r_y_max  <= RAW_BITS'(RST_MAX);
            r_width  <= SCREEN_BITS'(RST_WIDTH);
            r_height <= SCREEN_BITS'(RST_HEIGHT);
        end else if (w_wr) begin
            case (w_idx)
                REG_X_MIN:  r_x_min  <= pwdata[RAW_BITS-1:0];
                REG_X_MAX:  r_x_max  <= pwdata[RAW_BITS-1:0];
                REG_Y_MIN:  r_y_min  <= pwdata[RAW_BITS-1:0];
                REG_Y_MAX:  r_y_max  <= pwdata[RAW_BITS-1:0];
                REG_WIDTH:  r_width  <= pwdata[SCREEN_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[SCREEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_X_MIN:  prdata = DATA_BITS'(r_x_min);
            REG_X_MAX:  prdata = DATA_BITS'(r_x_max);
            REG_Y_MIN:  prdata = DATA_BITS'(r_y_min);
            REG_Y_MAX:  prdata = DATA_BITS'(r_y_max);
            REG_WIDTH:  prdata = DATA_BITS'(r_width);
            REG_HEIGHT: prdata = DATA_BITS'(r_height);
            default:    prdata = '0;
        endcase
    end

    assign o_x_min  = r_x_min;
    assign o_x_max  = r_x_max;
    assign o_y_min  = r_y_min;
    assign o_y_max  = r_y_max;
    assign o_width  = r_width;
    assign o_height = r_height;

endmodule
